/* rtl/ltge_pkg.sv */
// Package: shared opcodes, register indexes, field widths, size limits and rule constants.
`default_nettype none

package ltge_pkg;

  // Item opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int ROW_IN_W = 5;
  localparam int COL_IN_W = 7;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_DATA_W = 8;

  // Board size limits and reset sizes
  localparam int MIN_SIZE = 3;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd30;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd70;

  // Life rule
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

endpackage

`default_nettype wire

/* rtl/life_torus_generation_engine.sv */
// Top level: toroidal life board with write, read and advance items.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tdata: opcode, row, col, cell_in
//  m_*     | out       | m_tvalid / m_tready | m_tdata: cell_out
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Write and read go through the row memory: a row read, then a
// modify/write or a present. An advance walks the board one cell per cycle
// through one shared neighbor count unit, up to 32 rows by 128 columns at
// the default parameters.
// After reset a clearing pass over all MAX_ROWS rows zeroes the live copy
// before the first item is taken.
// A waiting read result holds the block in its output stage until m_tready.
`default_nettype none

module life_torus_generation_engine #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [1:0] opcode, [6:2] row, [13:7] col, [14] cell_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] cell_out
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [ltge_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RC_W  = ROW_W + 1;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CC_W  = COL_W + 1;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_FETCH = 4'd2;
  localparam logic [3:0] ST_WB    = 4'd3;
  localparam logic [3:0] ST_OUT   = 4'd4;
  localparam logic [3:0] ST_A_UP  = 4'd5;
  localparam logic [3:0] ST_A_MID = 4'd6;
  localparam logic [3:0] ST_A_DN  = 4'd7;
  localparam logic [3:0] ST_A_CAP = 4'd8;
  localparam logic [3:0] ST_A_CEL = 4'd9;
  localparam logic [3:0] ST_A_WB  = 4'd10;
  localparam logic [3:0] ST_A_CRD = 4'd11;
  localparam logic [3:0] ST_A_CWR = 4'd12;

  logic [3:0] state;

  // Configuration registers
  logic [ltge_pkg::ROWS_CFG_W-1:0] rows_in_use;
  logic [ltge_pkg::COLS_CFG_W-1:0] cols_in_use;

  // Latched item
  logic [ltge_pkg::OPCODE_W-1:0] item_op;
  logic [ltge_pkg::ROW_IN_W-1:0] item_row;
  logic [ltge_pkg::COL_IN_W-1:0] item_col;
  logic                          item_cell;

  // Live copy select and sweep counters
  logic            active;
  logic [RC_W-1:0] rc;
  logic [CC_W-1:0] cc;

  // Row window of the old generation and the row under construction
  logic [MAX_COLS-1:0] up_row;
  logic [MAX_COLS-1:0] mid_row;
  logic [MAX_COLS-1:0] dn_row;
  logic [MAX_COLS-1:0] new_row;

  // Row memory: two copies of the board, one row per word
  logic [MAX_COLS-1:0] mem [2][MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic                rd_copy;
  logic [ROW_W-1:0]    rd_row;
  logic                we;
  logic                wr_copy;
  logic [ROW_W-1:0]    wr_row;
  logic [MAX_COLS-1:0] wr_data;

  // Effective board size, clamped
  logic [RC_W-1:0] nr;
  logic [CC_W-1:0] nc;
  logic [RC_W-1:0] nr_m1;
  logic [CC_W-1:0] nc_m1;
  logic            on_board;

  always_comb begin
    if (int'(rows_in_use) < ltge_pkg::MIN_SIZE) begin
      nr = RC_W'(ltge_pkg::MIN_SIZE);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      nr = RC_W'(MAX_ROWS);
    end else begin
      nr = RC_W'(rows_in_use);
    end
    if (int'(cols_in_use) < ltge_pkg::MIN_SIZE) begin
      nc = CC_W'(ltge_pkg::MIN_SIZE);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      nc = CC_W'(MAX_COLS);
    end else begin
      nc = CC_W'(cols_in_use);
    end
    nr_m1  = nr - RC_W'(1);
    nc_m1  = nc - CC_W'(1);
    on_board = (int'(item_row) < int'(nr)) && (int'(item_col) < int'(nc));
  end

  // Shared neighbor count unit: one cell per cycle
  logic [COL_W-1:0] cidx;
  logic [COL_W-1:0] lf;
  logic [COL_W-1:0] rt;
  logic [CC_W-1:0]  cc_inc;
  logic [3:0]       ncount;
  logic             self_bit;
  logic             next_bit;

  always_comb begin
    cidx   = cc[COL_W-1:0];
    cc_inc = cc + CC_W'(1);
    lf     = (cc == '0) ? nc_m1[COL_W-1:0] : cidx - COL_W'(1);
    rt     = (cc_inc == nc) ? '0 : cc_inc[COL_W-1:0];
    self_bit = mid_row[cidx];
    ncount = 4'(up_row[lf]) + 4'(up_row[cidx]) + 4'(up_row[rt])
           + 4'(mid_row[lf]) + 4'(mid_row[rt])
           + 4'(dn_row[lf]) + 4'(dn_row[cidx]) + 4'(dn_row[rt]);
    if (self_bit) begin
      next_bit = (ncount == ltge_pkg::SURVIVE_LOW) || (ncount == ltge_pkg::SURVIVE_HIGH);
    end else begin
      next_bit = (ncount == ltge_pkg::BIRTH_COUNT);
    end
  end

  // Memory port control
  logic [RC_W-1:0] rc_p2;
  logic [MAX_COLS-1:0] mod_row;

  always_comb begin
    rc_p2   = rc + RC_W'(2);
    mod_row = rd_data;
    mod_row[COL_W'(item_col)] = item_cell;
    rd_copy = active;
    rd_row  = ROW_W'(item_row);
    we      = 1'b0;
    wr_copy = ~active;
    wr_row  = rc[ROW_W-1:0];
    wr_data = new_row;
    unique case (state)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_copy = active;
        wr_data = '0;
      end
      ST_WB: begin
        we      = on_board;
        wr_copy = active;
        wr_row  = ROW_W'(item_row);
        wr_data = mod_row;
      end
      ST_A_UP:  rd_row = nr_m1[ROW_W-1:0];
      ST_A_MID: rd_row = '0;
      ST_A_DN:  rd_row = ROW_W'(1);
      ST_A_WB: begin
        we     = 1'b1;
        rd_row = (rc_p2 == nr) ? '0 : rc_p2[ROW_W-1:0];
      end
      ST_A_CRD: rd_row = rc[ROW_W-1:0];
      ST_A_CWR: begin
        we      = 1'b1;
        wr_data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_copy][wr_row] <= wr_data;
    end
    rd_data <= mem[rd_copy][rd_row];
  end

  // Handshakes
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ltge_pkg::ROWS_RESET;
      cols_in_use <= ltge_pkg::COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ltge_pkg::CFG_ROWS: rows_in_use <= cfg_data[ltge_pkg::ROWS_CFG_W-1:0];
        ltge_pkg::CFG_COLS: cols_in_use <= cfg_data[ltge_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op   <= s_tdata[1:0];
      item_row  <= s_tdata[6:2];
      item_col  <= s_tdata[13:7];
      item_cell <= s_tdata[14];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      rc       <= '0;
      cc       <= '0;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken result unless the output stage reloads it now
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (rc == RC_W'(MAX_ROWS - 1)) begin
            state <= ST_IDLE;
          end
          rc <= rc + RC_W'(1);
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tdata[1:0]) inside
              ltge_pkg::OP_WRITE, ltge_pkg::OP_READ: state <= ST_FETCH;
              ltge_pkg::OP_ADVANCE:                  state <= ST_A_UP;
              default:                               state <= ST_IDLE;
            endcase
          end
        end
        ST_FETCH: begin
          state <= (item_op == ltge_pkg::OP_WRITE) ? ST_WB : ST_OUT;
        end
        ST_WB: state <= ST_IDLE;
        ST_OUT: begin
          // hold until the output stage is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, on_board & rd_data[COL_W'(item_col)]};
            state    <= ST_IDLE;
          end
        end
        ST_A_UP: begin
          rc    <= '0;
          state <= ST_A_MID;
        end
        ST_A_MID: begin
          up_row <= rd_data;
          state  <= ST_A_DN;
        end
        ST_A_DN: begin
          mid_row <= rd_data;
          state   <= ST_A_CAP;
        end
        ST_A_CAP: begin
          dn_row  <= rd_data;
          new_row <= mid_row;
          cc      <= '0;
          state   <= ST_A_CEL;
        end
        ST_A_CEL: begin
          new_row[cidx] <= next_bit;
          cc <= cc_inc;
          if (cc == nc_m1) begin
            state <= ST_A_WB;
          end
        end
        ST_A_WB: begin
          rc <= rc + RC_W'(1);
          if (rc == nr_m1) begin
            if (nr == RC_W'(MAX_ROWS)) begin
              active <= ~active;
              state  <= ST_IDLE;
            end else begin
              state <= ST_A_CRD;
            end
          end else begin
            up_row  <= mid_row;
            mid_row <= dn_row;
            state   <= ST_A_CAP;
          end
        end
        ST_A_CRD: state <= ST_A_CWR;
        ST_A_CWR: begin
          rc <= rc + RC_W'(1);
          if (rc == RC_W'(MAX_ROWS - 1)) begin
            active <= ~active;
            state  <= ST_IDLE;
          end else begin
            state <= ST_A_CRD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
